// ===== rtl/pswr_pkg.sv =====
// Package for the PNG stored-block stream writer: payload structs, job and
// phase types, constant byte tables, CRC-32 and field helper functions.
// No dependencies.
`timescale 1ns / 1ps

package pswr_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam logic [16:0] ADLER_MOD  = 17'd65521;
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_file;
  } out_item_t;

  // One unit of work for the back end.
  typedef struct packed {
    logic       start;     // emit the file header
    logic       row_head;  // emit block header and filter byte first
    logic       last_row;
    logic       final_px;  // emit the trailer after the pixel
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } job_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_SIG, PH_IHDR_LEN, PH_IHDR_TAG, PH_IHDR_DATA, PH_IHDR_CRC,
    PH_IDAT_LEN, PH_IDAT_TAG, PH_ZLIB, PH_ROW_HEAD, PH_PIXEL, PH_ADLER,
    PH_IDAT_CRC, PH_IEND_LEN, PH_IEND_TAG, PH_IEND_CRC
  } phase_t;

  localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                         8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam logic [7:0] TAG_IHDR [4] = '{8'h49, 8'h48, 8'h44, 8'h52};
  localparam logic [7:0] TAG_IDAT [4] = '{8'h49, 8'h44, 8'h41, 8'h54};
  localparam logic [7:0] TAG_IEND [4] = '{8'h49, 8'h45, 8'h4E, 8'h44};

  // Clamp a dimension register to 1..max.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] mx);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > mx) r = mx;
    return r;
  endfunction

  // Big-endian byte k of a 32-bit word.
  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = v[31:24];
      2'd1:    r = v[23:16];
      2'd2:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  // Reflected CRC-32 over one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Index of the final byte in each phase.
  function automatic logic [3:0] phase_last(input phase_t ph);
    logic [3:0] r;
    case (ph)
      PH_SIG:       r = 4'd7;
      PH_IHDR_DATA: r = 4'd12;
      PH_ZLIB:      r = 4'd1;
      PH_ROW_HEAD:  r = 4'd5;
      default:      r = 4'd3;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/png_stored_block_stream_writer.sv =====
// Top level of the PNG stored-block stream writer: configuration registers,
// front end, job queue and back end.
// Depends on pswr_pkg, pswr_front, pswr_queue, pswr_back.
`timescale 1ns / 1ps

//  channel   signals                          carries
//  input     in_valid / in_ready / in_data    mode and one RGB pixel
//  output    out_valid / out_ready / out_data one file byte with end flags
//  config    cfg_valid / cfg_ready /          register index and 13-bit value
//            cfg_index / cfg_data
//
// The back end emits one file byte per cycle while the output is not stalled; a pixel
// is four bytes, a row start ten, a start item 43 and the final pixel 24 (30 when
// it also opens its row).
// The front end takes a new item every cycle while the four-entry job queue
// has room; it drops pixels that arrive with no file open.
// A stalled output holds the byte in the output register; the back end then
// waits and the queue absorbs up to four more items.
// Reset (synchronous) closes any file, empties the queue and restores the
// image size to 1920 x 1080.

module png_stored_block_stream_writer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pswr_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pswr_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [pswr_pkg::DIM_W-1:0] cfg_data
);

  logic [pswr_pkg::DIM_W-1:0] image_width, image_height;
  logic [pswr_pkg::DIM_W-1:0] eff_width, eff_height;
  logic                       push, pop, q_full, q_not_empty;
  pswr_pkg::job_t             push_job, head_job;

  // Accept configuration transfers at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= pswr_pkg::DIM_W'(1920);
      image_height <= pswr_pkg::DIM_W'(1080);
    end else if (cfg_valid) begin
      case (cfg_index)
        pswr_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        pswr_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold sizes to their legal range before anyone uses them.
  assign eff_width  = pswr_pkg::clamp_dim(image_width,
                                          pswr_pkg::DIM_W'(pswr_pkg::MAX_WIDTH));
  assign eff_height = pswr_pkg::clamp_dim(image_height,
                                          pswr_pkg::DIM_W'(pswr_pkg::MAX_HEIGHT));

  pswr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .push       (push),
    .job        (push_job)
  );

  pswr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  pswr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_job       (head_job),
    .pop         (pop),
    .eff_width   (eff_width),
    .eff_height  (eff_height),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/pswr_front.sv =====
// Front end of the PNG writer: accepts input items, tracks row, column and
// open-file state, and classifies each item into a back-end job.
// Depends on pswr_pkg.
`timescale 1ns / 1ps

module pswr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pswr_pkg::in_item_t          in_data,
  input  logic                        q_full,
  input  logic [pswr_pkg::DIM_W-1:0]  eff_width,
  input  logic [pswr_pkg::DIM_W-1:0]  eff_height,
  output logic                        push,
  output pswr_pkg::job_t              job
);

  logic [11:0] column_index, column_index_next;
  logic [11:0] row_index, row_index_next;
  logic        frame_open, frame_open_next;
  logic        take;
  logic        row_end;
  logic        last_row;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign row_end  = ({1'b0, column_index} + 13'd1) >= eff_width;
  assign last_row = ({1'b0, row_index} + 13'd1) >= eff_height;

  always_comb begin
    column_index_next = column_index;
    row_index_next    = row_index;
    frame_open_next   = frame_open;
    push              = 1'b0;
    job.start         = 1'b0;
    job.row_head      = (column_index == '0);
    job.last_row      = last_row;
    job.final_px      = row_end && last_row;
    job.red           = in_data.red;
    job.green         = in_data.green;
    job.blue          = in_data.blue;
    if (take) begin
      if (in_data.mode == pswr_pkg::MODE_START) begin
        push              = 1'b1;
        job.start         = 1'b1;
        column_index_next = '0;
        row_index_next    = '0;
        frame_open_next   = 1'b1;
      end else if (frame_open) begin
        push = 1'b1;
        if (!row_end) begin
          column_index_next = column_index + 12'd1;
        end else begin
          column_index_next = '0;
          if (!last_row) begin
            row_index_next = row_index + 12'd1;
          end else begin
            row_index_next  = '0;
            frame_open_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
      frame_open   <= 1'b0;
    end else begin
      column_index <= column_index_next;
      row_index    <= row_index_next;
      frame_open   <= frame_open_next;
    end
  end

endmodule

// ===== rtl/pswr_queue.sv =====
// Job queue between front and back end of the PNG writer.
// Depends on pswr_pkg.
`timescale 1ns / 1ps

module pswr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pswr_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output pswr_pkg::job_t  head_job
);

  pswr_pkg::job_t                 slots [pswr_pkg::QUEUE_DEPTH];
  logic [pswr_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [pswr_pkg::QPTR_W:0]      count;

  assign full      = (count == (pswr_pkg::QPTR_W+1)'(pswr_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/pswr_back.sv =====
// Back end of the PNG writer: sequences the bytes of each job, keeps the
// CRC-32 and Adler-32 sums, and drives the registered output stage.
// Depends on pswr_pkg.
`timescale 1ns / 1ps

module pswr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_not_empty,
  input  pswr_pkg::job_t              q_job,
  output logic                        pop,
  input  logic [pswr_pkg::DIM_W-1:0]  eff_width,
  input  logic [pswr_pkg::DIM_W-1:0]  eff_height,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pswr_pkg::out_item_t         out_data
);

  pswr_pkg::phase_t phase, phase_next;
  logic [3:0]       cnt, cnt_next;
  pswr_pkg::job_t   cur, cur_next;
  logic [31:0]      crc_register, crc_next;
  logic [15:0]      adler_sum_a, adler_sum_a_next;
  logic [15:0]      adler_sum_b, adler_sum_b_next;
  logic [31:0]      data_chunk_len;
  logic [15:0]      row_len;
  logic             emit, last_in_phase, job_end, in_crc, in_adler;
  logic [7:0]       b;
  logic [31:0]      crc_base;
  logic [16:0]      a_sum, b_sum;
  logic [15:0]      a_mod;
  pswr_pkg::phase_t follow;

  assign row_len = 16'd1 + {1'b0, eff_width, 2'b00};

  // IDAT length = 6 + h * (6 + 4w); register the product.
  always_ff @(posedge clk) begin
    data_chunk_len <= 32'd6 + 32'(eff_height) * 32'(16'd5 + row_len);
  end

  always_comb begin
    emit          = (phase != pswr_pkg::PH_IDLE) && (!out_valid || out_ready);
    last_in_phase = (cnt == pswr_pkg::phase_last(phase));
    in_crc        = 1'b0;
    in_adler      = 1'b0;
    crc_base      = crc_register;
    b             = 8'h00;
    follow        = pswr_pkg::PH_IDLE;
    case (phase)
      pswr_pkg::PH_SIG: begin
        b = pswr_pkg::PNG_SIG[cnt[2:0]];
        follow = pswr_pkg::PH_IHDR_LEN;
      end
      pswr_pkg::PH_IHDR_LEN: begin
        b = pswr_pkg::be_byte(32'd13, cnt[1:0]);
        follow = pswr_pkg::PH_IHDR_TAG;
      end
      pswr_pkg::PH_IHDR_TAG: begin
        b = pswr_pkg::TAG_IHDR[cnt[1:0]];
        in_crc = 1'b1;
        if (cnt == '0) crc_base = '1;
        follow = pswr_pkg::PH_IHDR_DATA;
      end
      pswr_pkg::PH_IHDR_DATA: begin
        in_crc = 1'b1;
        if (cnt < 4'd4)       b = pswr_pkg::be_byte(32'(eff_width), cnt[1:0]);
        else if (cnt < 4'd8)  b = pswr_pkg::be_byte(32'(eff_height), cnt[1:0]);
        else if (cnt == 4'd8) b = 8'd8;
        else if (cnt == 4'd9) b = 8'd6;
        else                  b = 8'd0;
        follow = pswr_pkg::PH_IHDR_CRC;
      end
      pswr_pkg::PH_IHDR_CRC: begin
        b = pswr_pkg::be_byte(~crc_register, cnt[1:0]);
        follow = pswr_pkg::PH_IDAT_LEN;
      end
      pswr_pkg::PH_IDAT_LEN: begin
        b = pswr_pkg::be_byte(data_chunk_len, cnt[1:0]);
        follow = pswr_pkg::PH_IDAT_TAG;
      end
      pswr_pkg::PH_IDAT_TAG: begin
        b = pswr_pkg::TAG_IDAT[cnt[1:0]];
        in_crc = 1'b1;
        if (cnt == '0) crc_base = '1;
        follow = pswr_pkg::PH_ZLIB;
      end
      pswr_pkg::PH_ZLIB: begin
        b = (cnt == '0) ? 8'h78 : 8'h01;
        in_crc = 1'b1;
      end
      pswr_pkg::PH_ROW_HEAD: begin
        in_crc = 1'b1;
        case (cnt)
          4'd0:    b = {7'd0, cur.last_row};
          4'd1:    b = row_len[7:0];
          4'd2:    b = row_len[15:8];
          4'd3:    b = ~row_len[7:0];
          4'd4:    b = ~row_len[15:8];
          default: begin
            b = 8'h00;
            in_adler = 1'b1;
          end
        endcase
        follow = pswr_pkg::PH_PIXEL;
      end
      pswr_pkg::PH_PIXEL: begin
        in_crc   = 1'b1;
        in_adler = 1'b1;
        case (cnt[1:0])
          2'd0:    b = cur.red;
          2'd1:    b = cur.green;
          2'd2:    b = cur.blue;
          default: b = 8'hFF;
        endcase
        follow = cur.final_px ? pswr_pkg::PH_ADLER : pswr_pkg::PH_IDLE;
      end
      pswr_pkg::PH_ADLER: begin
        b = pswr_pkg::be_byte({adler_sum_b, adler_sum_a}, cnt[1:0]);
        in_crc = 1'b1;
        follow = pswr_pkg::PH_IDAT_CRC;
      end
      pswr_pkg::PH_IDAT_CRC: begin
        b = pswr_pkg::be_byte(~crc_register, cnt[1:0]);
        follow = pswr_pkg::PH_IEND_LEN;
      end
      pswr_pkg::PH_IEND_LEN: begin
        b = 8'h00;
        follow = pswr_pkg::PH_IEND_TAG;
      end
      pswr_pkg::PH_IEND_TAG: begin
        b = pswr_pkg::TAG_IEND[cnt[1:0]];
        in_crc = 1'b1;
        if (cnt == '0) crc_base = '1;
        follow = pswr_pkg::PH_IEND_CRC;
      end
      pswr_pkg::PH_IEND_CRC: begin
        b = pswr_pkg::be_byte(~crc_register, cnt[1:0]);
      end
      default: begin
        b = 8'h00;
      end
    endcase
    job_end = last_in_phase && (follow == pswr_pkg::PH_IDLE);

    // Adler sums: each stays below the modulus, so one subtract suffices.
    a_sum = {1'b0, adler_sum_a} + {9'd0, b};
    a_mod = (a_sum >= pswr_pkg::ADLER_MOD) ? 16'(a_sum - pswr_pkg::ADLER_MOD)
                                           : a_sum[15:0];
    b_sum = {1'b0, adler_sum_b} + {1'b0, a_mod};

    crc_next         = crc_register;
    adler_sum_a_next = adler_sum_a;
    adler_sum_b_next = adler_sum_b;
    phase_next       = phase;
    cnt_next         = cnt;
    cur_next         = cur;
    if (emit) begin
      if (in_crc) crc_next = pswr_pkg::crc_byte(crc_base, b);
      if (in_adler) begin
        adler_sum_a_next = a_mod;
        adler_sum_b_next = (b_sum >= pswr_pkg::ADLER_MOD)
                           ? 16'(b_sum - pswr_pkg::ADLER_MOD) : b_sum[15:0];
      end
      if (last_in_phase) begin
        phase_next = follow;
        cnt_next   = '0;
      end else begin
        cnt_next = cnt + 4'd1;
      end
    end

    // Load the next job when idle or right behind the final byte.
    pop = q_not_empty && ((phase == pswr_pkg::PH_IDLE) || (emit && job_end));
    if (pop) begin
      cur_next = q_job;
      cnt_next = '0;
      if (q_job.start) begin
        phase_next       = pswr_pkg::PH_SIG;
        adler_sum_a_next = 16'd1;
        adler_sum_b_next = 16'd0;
      end else if (q_job.row_head) begin
        phase_next = pswr_pkg::PH_ROW_HEAD;
      end else begin
        phase_next = pswr_pkg::PH_PIXEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= pswr_pkg::PH_IDLE;
      cnt          <= '0;
      crc_register <= '1;
      adler_sum_a  <= 16'd1;
      adler_sum_b  <= 16'd0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      cnt          <= cnt_next;
      crc_register <= crc_next;
      adler_sum_a  <= adler_sum_a_next;
      adler_sum_b  <= adler_sum_b_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (emit) begin
      out_data.out_byte    <= b;
      out_data.last_of_run <= job_end;
      out_data.end_of_file <= job_end && (phase == pswr_pkg::PH_IEND_CRC);
    end
  end

  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.end_of_file |-> out_data.last_of_run)
    else $error("end_of_file without last_of_run");

  a_trailer_final: assert property (@(posedge clk) disable iff (rst)
    phase == pswr_pkg::PH_ADLER |-> cur.final_px)
    else $error("trailer started for a non-final pixel");

  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    phase == pswr_pkg::PH_IDLE |-> cnt == '0)
    else $error("byte counter not cleared while idle");

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_not_empty)
    else $error("job taken from an empty queue");

endmodule

// ===== tb/png_file_byte_checker.sv =====
// Checker for the PNG stored-block stream writer: watches the three channels,
// predicts the file bytes of every accepted item and compares them in order.
// Depends on pswr_pkg.
`timescale 1ns / 1ps

module png_file_byte_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  pswr_pkg::in_item_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  pswr_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [pswr_pkg::DIM_W-1:0] cfg_data,
  output int                         errors,
  output int                         pending
);

  localparam logic [31:0] ID_IHDR = 32'h49484452;
  localparam logic [31:0] ID_IDAT = 32'h49444154;
  localparam logic [31:0] ID_IEND = 32'h49454E44;

  logic [pswr_pkg::DIM_W-1:0] width_setting, height_setting;
  logic [31:0]                chunk_crc;
  logic [15:0]                adler_lo, adler_hi;
  logic [11:0]                col_pos, row_pos;
  logic                       file_open;
  pswr_pkg::out_item_t        file_bytes_q[$];
  pswr_pkg::out_item_t        item_bytes_q[$];

  function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  function automatic int dim_used(input logic [pswr_pkg::DIM_W-1:0] v, input int mx);
    if (v == '0) return 1;
    if (int'(v) > mx) return mx;
    return int'(v);
  endfunction

  task automatic put_byte(input logic [7:0] b, input bit in_crc);
    pswr_pkg::out_item_t o;
    o = '{out_byte: b, last_of_run: 1'b0, end_of_file: 1'b0};
    item_bytes_q.push_back(o);
    if (in_crc) chunk_crc = crc_step(chunk_crc, b);
  endtask

  task automatic put_word(input logic [31:0] v, input bit in_crc);
    for (int k = 3; k >= 0; k--) put_byte(v[8*k +: 8], in_crc);
  endtask

  task automatic open_chunk(input logic [31:0] id, input logic [31:0] len);
    put_word(len, 1'b0);
    chunk_crc = '1;
    put_word(id, 1'b1);
  endtask

  task automatic close_chunk();
    put_word(~chunk_crc, 1'b0);
  endtask

  task automatic put_data_byte(input logic [7:0] b);
    put_byte(b, 1'b1);
    adler_lo = 16'((17'(adler_lo) + 17'(b)) % 17'd65521);
    adler_hi = 16'((17'(adler_hi) + 17'(adler_lo)) % 17'd65521);
  endtask

  // Work out every byte one accepted item causes and queue them.
  task automatic predict_file_bytes(input pswr_pkg::in_item_t it);
    int w, h, seg;
    bit last_row, done;
    logic [15:0] seg_len;
    w = dim_used(width_setting, pswr_pkg::MAX_WIDTH);
    h = dim_used(height_setting, pswr_pkg::MAX_HEIGHT);
    done = 1'b0;
    item_bytes_q.delete();
    if (it.mode == pswr_pkg::MODE_START) begin
      put_word(32'h89504E47, 1'b0);
      put_word(32'h0D0A1A0A, 1'b0);
      open_chunk(ID_IHDR, 32'd13);
      put_word(32'(w), 1'b1);
      put_word(32'(h), 1'b1);
      put_byte(8'd8, 1'b1);
      put_byte(8'd6, 1'b1);
      repeat (3) put_byte(8'd0, 1'b1);
      close_chunk();
      seg = 1 + 4 * w;
      open_chunk(ID_IDAT, 32'(2 + h * (5 + seg) + 4));
      put_byte(8'h78, 1'b1);
      put_byte(8'h01, 1'b1);
      adler_lo = 16'd1;
      adler_hi = 16'd0;
      col_pos = '0;
      row_pos = '0;
      file_open = 1'b1;
    end else if (file_open) begin
      last_row = (int'(row_pos) + 1 >= h);
      if (col_pos == '0) begin
        seg_len = 16'(1 + 4 * w);
        put_byte(last_row ? 8'h01 : 8'h00, 1'b1);
        put_byte(seg_len[7:0], 1'b1);
        put_byte(seg_len[15:8], 1'b1);
        put_byte(~seg_len[7:0], 1'b1);
        put_byte(~seg_len[15:8], 1'b1);
        put_data_byte(8'h00);
      end
      put_data_byte(it.red);
      put_data_byte(it.green);
      put_data_byte(it.blue);
      put_data_byte(8'hFF);
      if (int'(col_pos) + 1 < w) begin
        col_pos = col_pos + 1'b1;
      end else begin
        col_pos = '0;
        if (!last_row) begin
          row_pos = row_pos + 1'b1;
        end else begin
          put_word({adler_hi, adler_lo}, 1'b1);
          close_chunk();
          open_chunk(ID_IEND, 32'd0);
          close_chunk();
          row_pos = '0;
          file_open = 1'b0;
          done = 1'b1;
        end
      end
    end
    if (item_bytes_q.size() > 0) begin
      item_bytes_q[item_bytes_q.size() - 1].last_of_run = 1'b1;
      item_bytes_q[item_bytes_q.size() - 1].end_of_file = done;
    end
    foreach (item_bytes_q[i]) file_bytes_q.push_back(item_bytes_q[i]);
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    pswr_pkg::out_item_t want;
    if (rst) begin
      width_setting  <= pswr_pkg::DIM_W'(1920);
      height_setting <= pswr_pkg::DIM_W'(1080);
      chunk_crc = '1;
      adler_lo  = 16'd1;
      adler_hi  = 16'd0;
      col_pos   = '0;
      row_pos   = '0;
      file_open = 1'b0;
      file_bytes_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pswr_pkg::REG_IMAGE_WIDTH) width_setting <= cfg_data;
        else height_setting <= cfg_data;
      end
      if (in_valid && in_ready) predict_file_bytes(in_data);
      if (out_valid && out_ready) begin
        if (file_bytes_q.size() == 0) begin
          $error("unexpected byte %02h with nothing pending", out_data.out_byte);
          errors++;
        end else begin
          want = file_bytes_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
            errors++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   out_data.last_of_run);
            errors++;
          end
          if (out_data.end_of_file !== want.end_of_file) begin
            $error("end_of_file: expected %0b, got %0b", want.end_of_file,
                   out_data.end_of_file);
            errors++;
          end
        end
      end
    end
    pending = file_bytes_q.size();
  end

endmodule

// ===== tb/tb_png_stored_block_stream_writer.sv =====
// Testbench top for the PNG stored-block stream writer: clock, reset, stimulus
// for the pixel and configuration channels, output back-pressure and verdict.
// Depends on pswr_pkg, png_stored_block_stream_writer, png_file_byte_checker.
`timescale 1ns / 1ps

module tb_png_stored_block_stream_writer;

  logic                       clk;
  logic                       rst;
  logic                       in_valid, in_ready;
  pswr_pkg::in_item_t         in_data;
  logic                       out_valid, out_ready;
  pswr_pkg::out_item_t        out_data;
  logic                       cfg_valid, cfg_ready;
  logic                       cfg_index;
  logic [pswr_pkg::DIM_W-1:0] cfg_data;
  int                         errors, pending;

  // Stimulus counters and the switches that steer the output side.
  int items_sent;
  bit calm;       // no idling on either side
  bit hold_req;   // ask the receiver for one long stall
  bit hold_done;

  png_stored_block_stream_writer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  png_file_byte_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Output side: random bursts of ready and stall, one long stall on request,
  // and plain streaming once the run turns calm.
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  // Offer one item, maybe after an idle burst; return once it has transferred.
  task automatic send_item(input logic mode, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: mode, red: r, green: g, blue: b};
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_pixel();
    send_item(pswr_pkg::MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Drop valid and wait until every predicted byte has come out, then let
  // the design settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [pswr_pkg::DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(input logic [pswr_pkg::DIM_W-1:0] w,
                          input logic [pswr_pkg::DIM_W-1:0] h);
    write_reg(pswr_pkg::REG_IMAGE_WIDTH, w);
    write_reg(pswr_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  initial begin
    int w, h, npix;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = pswr_pkg::REG_IMAGE_WIDTH;
    cfg_data   = '0;
    items_sent = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: stray pixel with no file, abandoned file at reset size.
    send_item(pswr_pkg::MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(pswr_pkg::MODE_START, 8'h00, 8'h00, 8'h00);
    send_item(pswr_pkg::MODE_PIXEL, 8'h00, 8'h00, 8'h00);
    send_item(pswr_pkg::MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(pswr_pkg::MODE_START, 8'hFF, 8'hFF, 8'hFF);
    send_item(pswr_pkg::MODE_PIXEL, 8'h55, 8'hAA, 8'h5A);
    drain();

    // Complete 2x2 file, then a pixel after the file closed.
    set_size(13'd2, 13'd2);
    send_item(pswr_pkg::MODE_START, 8'h12, 8'h34, 8'h56);
    send_item(pswr_pkg::MODE_PIXEL, 8'hA5, 8'h5A, 8'h01);
    send_item(pswr_pkg::MODE_PIXEL, 8'h80, 8'h7F, 8'hFE);
    send_item(pswr_pkg::MODE_PIXEL, 8'h00, 8'hFF, 8'h00);
    send_item(pswr_pkg::MODE_PIXEL, 8'hFF, 8'h00, 8'hFF);
    send_item(pswr_pkg::MODE_PIXEL, 8'h11, 8'h22, 8'h33);
    drain();

    // Zero size clamps to 1x1.
    set_size(13'd0, 13'd0);
    send_item(pswr_pkg::MODE_START, 8'h00, 8'h00, 8'h00);
    send_item(pswr_pkg::MODE_PIXEL, 8'hC3, 8'h3C, 8'h99);
    drain();

    // All-ones register clamps to the maximum; leave the file unfinished.
    set_size(13'h1FFF, 13'h1FFF);
    send_item(pswr_pkg::MODE_START, 8'h00, 8'h00, 8'h00);
    send_random_pixel();
    send_random_pixel();
    drain();

    // Tallest image, one pixel wide; a few rows only.
    set_size(13'd1, 13'd4096);
    send_item(pswr_pkg::MODE_START, 8'h00, 8'h00, 8'h00);
    repeat (3) send_random_pixel();
    drain();

    // Random files: mostly whole, some cut short, some stray pixels.
    hold_req = 1'b1;
    while (items_sent < 270) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) w = 0;
      if ($urandom_range(0, 9) == 0) h = 0;
      set_size(pswr_pkg::DIM_W'(w), pswr_pkg::DIM_W'(h));
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 7) == 0) send_random_pixel();
        send_item(pswr_pkg::MODE_START, 8'($urandom), 8'($urandom), 8'($urandom));
        npix = w * h;
        if ($urandom_range(0, 5) == 0) npix = $urandom_range(0, npix - 1);
        repeat (npix) send_random_pixel();
        if ($urandom_range(0, 7) == 0) send_random_pixel();
      end
      drain();
    end

    // Last part: no idling, start of the widest row left open, then a small
    // complete file.
    calm = 1'b1;
    set_size(13'd4096, 13'd1);
    send_item(pswr_pkg::MODE_START, 8'h00, 8'h00, 8'h00);
    repeat (8) send_random_pixel();
    drain();
    set_size(13'd3, 13'd3);
    send_item(pswr_pkg::MODE_START, 8'h00, 8'h00, 8'h00);
    repeat (9) send_random_pixel();
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
